@@ sv/cmt_pkg.sv @@
// Package for the counted multiset table: operation codes, the controller
// command and status words, and fixed field widths of the ports.
// No dependencies.
package cmt_pkg;

  localparam int ModeBits  = 3;
  localparam int ValueWBits = 32;
  localparam int RankBits  = 5;
  localparam int CntOutBits = 16;
  localparam int TotalBits = 21;
  localparam int LiveBits  = 6;
  localparam int SlotsBits = 6;

  typedef enum logic [ModeBits-1:0] {
    MODE_INSERT    = 3'd0,
    MODE_ERASE_ONE = 3'd1,
    MODE_ERASE_ALL = 3'd2,
    MODE_COUNT     = 3'd3,
    MODE_GET       = 3'd4
  } mode_e;

  // controller to datapath
  typedef struct packed {
    logic start;       // latch the incoming word and arm the scan
    logic issue;       // read the next slot
    logic clear_step;  // zero one slot of the clearing pass
    logic finish;      // commit the update and load the result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic more;        // slots left to read in this scan
    logic scan_done;   // scan finished, result known
    logic clear_last;  // clearing pass at its last slot
    logic out_free;    // result register can take a word this cycle
  } dp_status_t;

endpackage

@@ sv/cmt_ctrl.sv @@
// Controller state machine for the counted multiset table.
// Uses cmt_pkg for the command and status words.
module cmt_ctrl
  import cmt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       cfg_we_i,
  input  dp_status_t status_i,
  output logic       in_ready_o,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.issue = status_i.more;
        if (status_i.scan_done) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
    // a register write empties the table: restart the clearing pass
    if (cfg_we_i) begin
      state_d    = S_CLEAR;
      cmd_o      = '0;
      in_ready_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/cmt_datapath.sv @@
// Datapath of the counted multiset table: slot memory, scan registers,
// running totals and the result register. Uses cmt_pkg.
module cmt_datapath
  import cmt_pkg::*;
#(
  parameter int CAPACITY   = 32,
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  input  logic                  cfg_we_i,
  input  logic [SlotsBits-1:0]  cfg_wdata_i,
  input  logic [ModeBits-1:0]   mode_i,
  input  logic [ValueWBits-1:0] item_value_i,
  input  logic [RankBits-1:0]   rank_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  ok_o,
  output logic [CntOutBits-1:0] count_out_o,
  output logic [ValueWBits-1:0] item_out_o,
  output logic [TotalBits-1:0]  total_items_o,
  output logic [LiveBits-1:0]   unique_items_o,
  output logic                  is_empty_o
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > SlotsBits) ? CW : SlotsBits;
  localparam int EW = COUNT_BITS + VALUE_BITS;
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  // slot memory: {count, value}
  logic [EW-1:0] mem [CAPACITY];

  logic [SlotsBits-1:0]  slots_q;
  logic [TotalBits-1:0]  total_q, total_d;
  logic [LiveBits-1:0]   live_q, live_d;
  logic [LW-1:0]         scan_q, lim;
  mode_e                 mode_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [RankBits-1:0]   rank_q, seen_q;
  logic                  no_scan_q;
  logic                  rv_q;
  logic [IW-1:0]         rd_idx_q;
  logic [EW-1:0]         rdata_q;
  logic                  found_q, free_q;
  logic [IW-1:0]         hit_idx_q, free_idx_q;
  logic [COUNT_BITS-1:0] hit_cnt_q;
  logic [VALUE_BITS-1:0] hit_val_q;

  logic [COUNT_BITS-1:0] rd_cnt;
  logic [VALUE_BITS-1:0] rd_val;
  logic                  rd_live;

  logic                  fin_we;
  logic [IW-1:0]         fin_idx;
  logic [COUNT_BITS-1:0] fin_cnt;
  logic                  res_ok;
  logic [COUNT_BITS-1:0] res_cnt;
  logic [VALUE_BITS-1:0] res_item;

  logic                  mem_we;
  logic [IW-1:0]         mem_widx;
  logic [EW-1:0]         mem_wdata;

  logic                  out_valid_q;

  // usable slots: a register value above the capacity acts as the capacity
  always_comb begin
    if (LW'(slots_q) > LW'(CAPACITY)) lim = LW'(CAPACITY);
    else                              lim = LW'(slots_q);
  end

  assign rd_cnt  = rdata_q[EW-1:VALUE_BITS];
  assign rd_val  = rdata_q[VALUE_BITS-1:0];
  assign rd_live = (rd_cnt != '0);

  assign status_o.more       = !no_scan_q && !found_q && (scan_q < lim);
  assign status_o.scan_done  = found_q || (!status_o.more && !rv_q);
  assign status_o.clear_last = (scan_q == LW'(CAPACITY - 1));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // commit of one operation
  always_comb begin
    fin_we   = 1'b0;
    fin_idx  = hit_idx_q;
    fin_cnt  = '0;
    res_ok   = 1'b0;
    res_cnt  = '0;
    res_item = '0;
    total_d  = total_q;
    live_d   = live_q;
    case (mode_q)
      MODE_INSERT: begin
        if (found_q) begin
          res_cnt = hit_cnt_q;
          if (hit_cnt_q != CountMax) begin
            fin_we  = 1'b1;
            fin_cnt = hit_cnt_q + COUNT_BITS'(1);
            res_cnt = fin_cnt;
            res_ok  = 1'b1;
            total_d = total_q + TotalBits'(1);
          end
        end else if (free_q) begin
          fin_we  = 1'b1;
          fin_idx = free_idx_q;
          fin_cnt = COUNT_BITS'(1);
          res_cnt = fin_cnt;
          res_ok  = 1'b1;
          total_d = total_q + TotalBits'(1);
          live_d  = live_q + LiveBits'(1);
        end
      end
      MODE_ERASE_ONE: begin
        if (found_q) begin
          fin_we  = 1'b1;
          fin_cnt = hit_cnt_q - COUNT_BITS'(1);
          res_cnt = fin_cnt;
          res_ok  = 1'b1;
          total_d = total_q - TotalBits'(1);
          if (fin_cnt == '0) live_d = live_q - LiveBits'(1);
        end
      end
      MODE_ERASE_ALL: begin
        if (found_q) begin
          fin_we  = 1'b1;
          res_cnt = hit_cnt_q;
          res_ok  = 1'b1;
          total_d = total_q - TotalBits'(hit_cnt_q);
          live_d  = live_q - LiveBits'(1);
        end
      end
      MODE_COUNT: begin
        if (found_q) begin
          res_cnt = hit_cnt_q;
          res_ok  = 1'b1;
        end
      end
      MODE_GET: begin
        if (found_q) begin
          res_cnt  = hit_cnt_q;
          res_item = hit_val_q;
          res_ok   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // single write port: clearing pass or commit
  always_comb begin
    mem_we    = cmd_i.clear_step || (cmd_i.finish && fin_we);
    mem_widx  = cmd_i.clear_step ? scan_q[IW-1:0] : fin_idx;
    mem_wdata = cmd_i.clear_step ? '0 : {fin_cnt, val_q};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_widx] <= mem_wdata;
    if (cmd_i.issue) rdata_q <= mem[scan_q[IW-1:0]];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q     <= SlotsBits'(32);
      total_q     <= '0;
      live_q      <= '0;
      scan_q      <= '0;
      rv_q        <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      no_scan_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rv_q <= cmd_i.issue;
      if (cmd_i.issue || cmd_i.clear_step) scan_q <= scan_q + LW'(1);
      if (cmd_i.start) begin
        scan_q    <= '0;
        found_q   <= 1'b0;
        free_q    <= 1'b0;
        no_scan_q <= (mode_i > ModeBits'(MODE_GET)) ||
                     ((mode_i == ModeBits'(MODE_GET)) &&
                      (LiveBits'(rank_i) >= live_q));
      end
      if (rv_q && !found_q) begin
        if (mode_q == MODE_GET) begin
          if (rd_live && seen_q == rank_q) found_q <= 1'b1;
        end else begin
          if (rd_live && rd_val == val_q) found_q <= 1'b1;
          if (mode_q == MODE_INSERT && !rd_live && !free_q) free_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        total_q     <= total_d;
        live_q      <= live_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        slots_q <= cfg_wdata_i;
        total_q <= '0;
        live_q  <= '0;
        scan_q  <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mode_q <= mode_e'(mode_i);
      val_q  <= VALUE_BITS'(item_value_i);
      rank_q <= rank_i;
      seen_q <= '0;
    end
    if (cmd_i.issue) rd_idx_q <= scan_q[IW-1:0];
    if (rv_q && !found_q) begin
      if (mode_q == MODE_GET) begin
        if (rd_live) begin
          if (seen_q == rank_q) begin
            hit_idx_q <= rd_idx_q;
            hit_cnt_q <= rd_cnt;
            hit_val_q <= rd_val;
          end else begin
            seen_q <= seen_q + RankBits'(1);
          end
        end
      end else begin
        if (rd_live && rd_val == val_q) begin
          hit_idx_q <= rd_idx_q;
          hit_cnt_q <= rd_cnt;
        end
        if (!rd_live && !free_q) free_idx_q <= rd_idx_q;
      end
    end
    if (cmd_i.finish) begin
      ok_o           <= res_ok;
      count_out_o    <= CntOutBits'(res_cnt);
      item_out_o     <= ValueWBits'(res_item);
      total_items_o  <= total_d;
      unique_items_o <= live_d;
      is_empty_o     <= (live_d == '0);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/counted_multiset_table_core.sv @@
// Top level of the counted multiset table: controller and datapath.
// Depends on cmt_pkg, cmt_ctrl and cmt_datapath.
//
//  channel   direction  handshake               payload
//  in        input      in_valid_i/in_ready_o    mode_i, item_value_i, rank_i
//  out       output     out_valid_o/out_ready_i  ok_o, count_out_o, item_out_o,
//                                                total_items_o, unique_items_o,
//                                                is_empty_o
//  cfg       input      cfg_we_i                 cfg_wdata_i (slots_in_use)
//
// Scan: each word is served by a linear scan of the single-read-port slot
//   memory, one slot per cycle; a scan stops early at a match. Get with an
//   out-of-range rank, an unused mode or a table with no usable slots reads
//   no slot at all.
// Reset: a clearing pass over all CAPACITY slots zeroes the slot memory; no word
//   is accepted during it. A configuration write restarts the same pass and
//   holds ready low in its cycle.
// Stalls: the next word is accepted while the result register still waits;
//   the commit of that next word holds until the result register is free.
module counted_multiset_table_core
  import cmt_pkg::*;
#(
  parameter int CAPACITY   = 32,
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ModeBits-1:0]   mode_i,
  input  logic [ValueWBits-1:0] item_value_i,
  input  logic [RankBits-1:0]   rank_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  ok_o,
  output logic [CntOutBits-1:0] count_out_o,
  output logic [ValueWBits-1:0] item_out_o,
  output logic [TotalBits-1:0]  total_items_o,
  output logic [LiveBits-1:0]   unique_items_o,
  output logic                  is_empty_o,
  input  logic                  cfg_we_i,
  input  logic [SlotsBits-1:0]  cfg_wdata_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequence: clearing pass, wait for a word, scan, commit
  cmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cfg_we_i   (cfg_we_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // slot memory, match search and the result register
  cmt_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mode_i         (mode_i),
    .item_value_i   (item_value_i),
    .rank_i         (rank_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .ok_o           (ok_o),
    .count_out_o    (count_out_o),
    .item_out_o     (item_out_o),
    .total_items_o  (total_items_o),
    .unique_items_o (unique_items_o),
    .is_empty_o     (is_empty_o)
  );

endmodule

@@ sv/cmt_checker.sv @@
// Port-level checks for the counted multiset table, bound to the top level.
// Depends on cmt_pkg and counted_multiset_table_core.
module cmt_checker
  import cmt_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  ok_o,
  input logic [CntOutBits-1:0] count_out_o,
  input logic [ValueWBits-1:0] item_out_o,
  input logic [TotalBits-1:0]  total_items_o,
  input logic [LiveBits-1:0]   unique_items_o,
  input logic                  is_empty_o
);

  // empty flag agrees with the live slot count
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (unique_items_o == '0)))
    else $error("is_empty disagrees with unique_items");

  // no live slot means no counted item
  a_empty_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_empty_o) |-> (total_items_o == '0))
    else $error("empty table reports a nonzero total");

  // a failed operation returns no value
  a_fail_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (item_out_o == '0))
    else $error("item_out nonzero on a failed operation");

  // one word in flight: ready drops after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second word accepted while one is in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(count_out_o)))
    else $error("result dropped or changed under stall");

endmodule

bind counted_multiset_table_core cmt_checker u_cmt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .ok_o           (ok_o),
  .count_out_o    (count_out_o),
  .item_out_o     (item_out_o),
  .total_items_o  (total_items_o),
  .unique_items_o (unique_items_o),
  .is_empty_o     (is_empty_o)
);

@@ test/tb.sv @@
// Self-checking bench for counted_multiset_table_core: a queue-fed driver, a
// result monitor and a behavioural predictor of the slot table.
// Depends on cmt_pkg and counted_multiset_table_core.
`timescale 1ns / 100ps

module tb
  import cmt_pkg::*;
;

  localparam int  CAP            = 32;
  localparam int  HOLD_CYCLES    = 300;
  localparam int  TAIL_CYCLES    = 2 * CAP + 16;
  localparam int  REPEAT_INSERTS = 20;
  localparam int  MAX_REPORTS    = 10;
  localparam longint TIMEOUT_NS  = 64'd10_000_000;

  localparam logic [CntOutBits-1:0] CNT_CEIL = '1;
  localparam logic [ModeBits-1:0]   MODE_FIRST_UNUSED = ModeBits'(MODE_GET + 1);
  localparam logic [ModeBits-1:0]   MODE_LAST_UNUSED  = '1;
  localparam logic [ValueWBits-1:0] VALUE_TOP = '1;
  localparam logic [RankBits-1:0]   RANK_TOP  = '1;

  // one input word and one result word
  typedef struct packed {
    logic [ModeBits-1:0]   mode;
    logic [ValueWBits-1:0] value;
    logic [RankBits-1:0]   rank;
  } word_t;

  typedef struct packed {
    logic                  ok;
    logic [CntOutBits-1:0] cnt;
    logic [ValueWBits-1:0] item;
    logic [TotalBits-1:0]  total;
    logic [LiveBits-1:0]   uniq;
    logic                  none_live;
  } result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [ModeBits-1:0]   mode_i;
  logic [ValueWBits-1:0] item_value_i;
  logic [RankBits-1:0]   rank_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  ok_o;
  logic [CntOutBits-1:0] count_out_o;
  logic [ValueWBits-1:0] item_out_o;
  logic [TotalBits-1:0]  total_items_o;
  logic [LiveBits-1:0]   unique_items_o;
  logic                  is_empty_o;
  logic                  cfg_we_i;
  logic [SlotsBits-1:0]  cfg_wdata_i;

  counted_multiset_table_core #(
    .CAPACITY  (CAP),
    .VALUE_BITS(ValueWBits),
    .COUNT_BITS(CntOutBits)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .item_value_i  (item_value_i),
    .rank_i        (rank_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .ok_o          (ok_o),
    .count_out_o   (count_out_o),
    .item_out_o    (item_out_o),
    .total_items_o (total_items_o),
    .unique_items_o(unique_items_o),
    .is_empty_o    (is_empty_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the slot table and its size register.
  // ---------------------------------------------------------------------------
  logic [ValueWBits-1:0] slot_val [CAP];
  logic [CntOutBits-1:0] slot_cnt [CAP];
  logic [SlotsBits-1:0]  slots_cfg;
  int                    sum_cnt;
  int                    live_n;

  word_t                 pending_words[$];    // words waiting for the driver
  result_t               expected_results[$]; // predictions awaiting the block
  logic [ValueWBits-1:0] value_pool[$];       // values that random words draw on

  int  words_sent   = 0;
  int  words_taken  = 0;
  int  results_seen = 0;
  int  fail_count   = 0;
  int  size_changes = 0;
  bit  idle_on      = 1'b1;
  bit  hold_arm     = 1'b0;
  bit  hold_done    = 1'b0;
  int  hold_left    = 0;
  bit  calm         = 1'b0;
  int  calm_left    = 0;
  bit  in_took      = 1'b0;
  int  send_gap     = 0;
  int  rx_gap       = 0;

  // Empty the predicted table, as a size write does.
  function automatic void clear_slots();
    for (int k = 0; k < CAP; k++) begin
      slot_val[k] = '0;
      slot_cnt[k] = '0;
    end
    sum_cnt = 0;
    live_n  = 0;
  endfunction

  // Apply one word to the predicted table and return the result it yields.
  function automatic result_t table_apply(word_t w);
    result_t r;
    int      lim;
    int      hit;
    int      seen;
    r    = '0;
    lim  = (slots_cfg > CAP) ? CAP : int'(slots_cfg);
    hit  = -1;
    seen = 0;
    // matching looks at live slots only, first one wins
    for (int k = 0; k < lim; k++)
      if (hit < 0 && slot_cnt[k] != 0 && slot_val[k] == w.value) hit = k;
    case (w.mode)
      MODE_INSERT: begin
        if (hit >= 0) begin
          r.cnt = slot_cnt[hit];
          if (slot_cnt[hit] != CNT_CEIL) begin
            slot_cnt[hit] = slot_cnt[hit] + CntOutBits'(1);
            r.cnt   = slot_cnt[hit];
            sum_cnt = sum_cnt + 1;
            r.ok    = 1'b1;
          end
        end else begin
          for (int k = 0; k < lim; k++) begin
            if (!r.ok && slot_cnt[k] == 0) begin
              slot_val[k] = w.value;
              slot_cnt[k] = CntOutBits'(1);
              sum_cnt     = sum_cnt + 1;
              live_n      = live_n + 1;
              r.ok        = 1'b1;
              r.cnt       = CntOutBits'(1);
            end
          end
        end
      end
      MODE_ERASE_ONE, MODE_ERASE_ALL, MODE_COUNT: begin
        if (hit >= 0) begin
          r.ok  = 1'b1;
          r.cnt = slot_cnt[hit];
          if (w.mode == MODE_ERASE_ONE) begin
            slot_cnt[hit] = slot_cnt[hit] - CntOutBits'(1);
            r.cnt   = slot_cnt[hit];
            sum_cnt = sum_cnt - 1;
            if (slot_cnt[hit] == 0) live_n = live_n - 1;
          end else if (w.mode == MODE_ERASE_ALL) begin
            sum_cnt       = sum_cnt - int'(slot_cnt[hit]);
            slot_cnt[hit] = '0;
            live_n        = live_n - 1;
          end
        end
      end
      MODE_GET: begin
        if (int'(w.rank) < live_n) begin
          for (int k = 0; k < lim; k++) begin
            if (!r.ok && slot_cnt[k] != 0) begin
              if (seen == int'(w.rank)) begin
                r.ok   = 1'b1;
                r.cnt  = slot_cnt[k];
                r.item = slot_val[k];
              end
              seen++;
            end
          end
        end
      end
      default: ;
    endcase
    r.total     = TotalBits'(sum_cnt);
    r.uniq      = LiveBits'(live_n);
    r.none_live = (live_n == 0);
    return r;
  endfunction

  function automatic word_t mk(logic [ModeBits-1:0] m, logic [ValueWBits-1:0] v,
                               logic [RankBits-1:0] rk);
    word_t w;
    w.mode  = m;
    w.value = v;
    w.rank  = rk;
    return w;
  endfunction

  // Draw a word: mostly pool values so that inserts, erases and counts hit,
  // with a share of fully random values, wide ranks and spare modes.
  function automatic word_t random_word();
    word_t w;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      w.mode = MODE_INSERT;
    else if (pick < 55) w.mode = MODE_ERASE_ONE;
    else if (pick < 63) w.mode = MODE_ERASE_ALL;
    else if (pick < 75) w.mode = MODE_COUNT;
    else if (pick < 95) w.mode = MODE_GET;
    else w.mode = ModeBits'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST_UNUSED));
    if ($urandom_range(0, 9) == 0) w.value = $urandom;
    else w.value = value_pool[$urandom_range(0, value_pool.size() - 1)];
    if ($urandom_range(0, 3) == 0) w.rank = RankBits'($urandom_range(0, RANK_TOP));
    else w.rank = RankBits'($urandom_range(0, 7));
    return w;
  endfunction

  // Seed the pool with both value extremes and random fill.
  task automatic fill_pool(input int n);
    value_pool.delete();
    value_pool.push_back('0);
    value_pool.push_back(VALUE_TOP);
    while (value_pool.size() < n) value_pool.push_back($urandom);
  endtask

  task automatic queue_random(input int n);
    for (int k = 0; k < n; k++) pending_words.push_back(random_word());
  endtask

  // Hold until every queued word has gone in and every result has come back,
  // then let the block settle before anything else touches it.
  task automatic wait_drained();
    while (pending_words.size() != 0 || words_sent != words_taken ||
           expected_results.size() != 0)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  // Write the slot count; the block empties its table and reruns its clear.
  task automatic write_slots(input int n);
    @(negedge clk_i);
    cfg_wdata_i <= SlotsBits'(n);
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    slots_cfg = SlotsBits'(n);
    clear_slots();
    size_changes++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock and timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[counted_multiset_table_core] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: advance to the next pending word once the current one is taken,
  // hold the payload steady while it waits, and drop valid for idle bursts.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    word_t w;
    if (rst_ni) begin
      if (in_valid_i && !in_took) begin
        // hold: word still on offer
      end else if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (idle_on && !calm && in_took && $urandom_range(0, 3) == 0) begin
        send_gap = $urandom_range(0, 15);
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        w = pending_words.pop_front();
        words_sent++;
        in_valid_i   <= 1'b1;
        mode_i       <= w.mode;
        item_value_i <= w.value;
        rank_i       <= w.rank;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus the long hold-off that backs the
  // block up until it stops taking words.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_gap != 0) rx_gap--;
      else if (idle_on && !calm && $urandom_range(0, 9) == 0) rx_gap = $urandom_range(1, 16);
      out_ready_i <= (rx_gap == 0) && (hold_left == 0);
    end
  end

  // Cycle counters for the hold-off and for calm stretches without idling.
  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_arm && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
    if (calm_left != 0) calm_left <= calm_left - 1;
    else begin
      calm      <= !calm;
      calm_left <= $urandom_range(100, 400);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result word against the oldest prediction, then
  // predict for any word taken on this edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.ok        = ok_o;
        got.cnt       = count_out_o;
        got.item      = item_out_o;
        got.total     = total_items_o;
        got.uniq      = unique_items_o;
        got.none_live = is_empty_o;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result word %0d: ok=%0d cnt=%0d item=%h", results_seen,
                     got.ok, got.cnt, got.item);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("mismatch on result %0d: exp ok=%0d cnt=%0d item=%h total=%0d %s",
                       results_seen, want.ok, want.cnt, want.item, want.total, "");
              $display("  exp live=%0d empty=%0d", want.uniq, want.none_live);
              $display("  got ok=%0d cnt=%0d item=%h total=%0d live=%0d empty=%0d",
                       got.ok, got.cnt, got.item, got.total, got.uniq, got.none_live);
            end
          end
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(table_apply(mk(mode_i, item_value_i, rank_i)));
        words_taken++;
      end
      in_took <= in_valid_i && in_ready_o;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, then a series of table sizes, each with its own words.
  // ---------------------------------------------------------------------------
  initial begin
    logic [ValueWBits-1:0] sat_value;
    logic [ValueWBits-1:0] other_value;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    mode_i       = '0;
    item_value_i = '0;
    rank_i       = '0;
    out_ready_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    slots_cfg    = SlotsBits'(CAP);
    clear_slots();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Full-size table from reset: misses on an empty table, value extremes,
    // a hole left by erase-all and refilled by the next insert, rank misses
    // and the spare mode codes.
    pending_words.push_back(mk(MODE_COUNT, '0, '0));
    pending_words.push_back(mk(MODE_ERASE_ONE, '0, '0));
    pending_words.push_back(mk(MODE_ERASE_ALL, VALUE_TOP, RANK_TOP));
    pending_words.push_back(mk(MODE_GET, '0, '0));
    pending_words.push_back(mk(MODE_INSERT, '0, '0));
    pending_words.push_back(mk(MODE_INSERT, VALUE_TOP, '0));
    pending_words.push_back(mk(MODE_INSERT, VALUE_TOP, RANK_TOP));
    pending_words.push_back(mk(MODE_COUNT, VALUE_TOP, '0));
    pending_words.push_back(mk(MODE_GET, '0, 5'd1));
    pending_words.push_back(mk(MODE_GET, VALUE_TOP, RANK_TOP));
    pending_words.push_back(mk(MODE_ERASE_ONE, VALUE_TOP, '0));
    pending_words.push_back(mk(MODE_INSERT, 32'hA5A5_5A5A, '0));
    pending_words.push_back(mk(MODE_ERASE_ALL, '0, '0));
    pending_words.push_back(mk(MODE_GET, '0, '0));
    pending_words.push_back(mk(MODE_INSERT, 32'h1234_5678, '0));
    pending_words.push_back(mk(MODE_GET, '0, '0));
    pending_words.push_back(mk(MODE_ERASE_ALL, VALUE_TOP, '0));
    for (int m = MODE_FIRST_UNUSED; m <= MODE_LAST_UNUSED; m++)
      pending_words.push_back(mk(ModeBits'(m), VALUE_TOP, RANK_TOP));
    pending_words.push_back(mk(MODE_ERASE_ONE, 32'hA5A5_5A5A, '0));
    pending_words.push_back(mk(MODE_ERASE_ONE, 32'h1234_5678, '0));
    pending_words.push_back(mk(MODE_COUNT, 32'h1234_5678, '0));
    wait_drained();

    // Random words at full size; arm the long receiver hold-off here.
    fill_pool(12);
    queue_random(400);
    hold_arm = 1'b1;
    wait_drained();

    // One slot: the table is full after a single distinct value.
    write_slots(1);
    fill_pool(3);
    queue_random(80);
    wait_drained();

    // No slots at all: every insert fails, nothing ever goes live.
    write_slots(0);
    fill_pool(4);
    queue_random(30);
    wait_drained();

    // Oversized count, behaves as the full capacity; pool big enough to fill.
    write_slots(63);
    fill_pool(40);
    queue_random(300);
    wait_drained();

    write_slots(5);
    fill_pool(8);
    queue_random(300);
    wait_drained();

    // Fill all slots with distinct values, overflow, punch a hole, refill.
    write_slots(CAP);
    fill_pool(CAP + 1);
    for (int k = 0; k <= CAP; k++) pending_words.push_back(mk(MODE_INSERT, value_pool[k], '0));
    pending_words.push_back(mk(MODE_GET, '0, RANK_TOP));
    pending_words.push_back(mk(MODE_ERASE_ALL, value_pool[7], '0));
    pending_words.push_back(mk(MODE_INSERT, value_pool[CAP], '0));
    pending_words.push_back(mk(MODE_GET, '0, 5'd7));
    queue_random(60);
    wait_drained();

    // Last stretch, no idling: pile up one count on a single slot, then
    // offer a second value to the full table.
    idle_on = 1'b0;
    write_slots(1);
    sat_value   = $urandom;
    other_value = ~sat_value;
    for (int k = 0; k < REPEAT_INSERTS; k++)
      pending_words.push_back(mk(MODE_INSERT, sat_value, '0));
    pending_words.push_back(mk(MODE_INSERT, sat_value, '0));
    pending_words.push_back(mk(MODE_ERASE_ONE, sat_value, '0));
    pending_words.push_back(mk(MODE_INSERT, sat_value, '0));
    pending_words.push_back(mk(MODE_INSERT, sat_value, '0));
    pending_words.push_back(mk(MODE_INSERT, other_value, '0));
    pending_words.push_back(mk(MODE_COUNT, sat_value, '0));
    pending_words.push_back(mk(MODE_GET, other_value, '0));
    pending_words.push_back(mk(MODE_ERASE_ALL, sat_value, '0));
    pending_words.push_back(mk(MODE_GET, sat_value, '0));
    wait_drained();

    $display("Summary: %0d words over %0d size writes (sizes 0, 1, 5, 32 and oversized 63);",
             words_taken, size_changes);
    $display("  covered full tables, refilled holes, rank misses, spare modes and a long hold-off.");
    if (fail_count == 0) begin
      $display("[counted_multiset_table_core] OK");
    end else begin
      $display("%0d result words failed the check", fail_count);
      $display("[counted_multiset_table_core] ERROR");
    end
    $finish;
  end

endmodule
